// ===== hdl/smbus_read_byte_data_master_top_assert.svh =====
// Assertion macros for the SMBus read-byte-data master.
`ifndef SMBUS_READ_BYTE_DATA_MASTER_TOP_ASSERT_SVH
`define SMBUS_READ_BYTE_DATA_MASTER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRBD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/srbd_pkg.sv =====
// Types, widths and pin level table for the SMBus read-byte-data master.
package srbd_pkg;

  localparam int unsigned StepW   = 16;
  localparam int unsigned AddrW   = 7;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned BitCntW = 4;
  localparam int unsigned PhaseW  = 25;

  // One-hot sequencer phases, in bus order
  typedef enum logic [PhaseW-1:0] {
    PH_IDLE        = 25'h0000001,
    PH_ST_SETUP    = 25'h0000002,
    PH_ST_START    = 25'h0000004,
    PH_AW_LOW      = 25'h0000008,
    PH_AW_HIGH     = 25'h0000010,
    PH_AW_ACK_LOW  = 25'h0000020,
    PH_AW_ACK_HIGH = 25'h0000040,
    PH_RG_LOW      = 25'h0000080,
    PH_RG_HIGH     = 25'h0000100,
    PH_RG_ACK_LOW  = 25'h0000200,
    PH_RG_ACK_HIGH = 25'h0000400,
    PH_RS_LOW      = 25'h0000800,
    PH_RS_SETUP    = 25'h0001000,
    PH_RS_START    = 25'h0002000,
    PH_AR_LOW      = 25'h0004000,
    PH_AR_HIGH     = 25'h0008000,
    PH_AR_ACK_LOW  = 25'h0010000,
    PH_AR_ACK_HIGH = 25'h0020000,
    PH_RD_LOW      = 25'h0040000,
    PH_RD_HIGH     = 25'h0080000,
    PH_NACK_LOW    = 25'h0100000,
    PH_NACK_HIGH   = 25'h0200000,
    PH_SP_LOW      = 25'h0400000,
    PH_SP_HIGH     = 25'h0800000,
    PH_SP_END      = 25'h1000000
  } phase_e;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } pins_t;

  typedef struct packed {
    pins_t            pins;
    logic             busy;
    logic             done;
    logic             success;
    logic [ByteW-1:0] read_data;
  } res_t;

  // Pin levels for a phase; bit phases drive the MSB of the shift byte
  function automatic pins_t levels_for(phase_e ph, logic bit_lvl);
    pins_t p;
    case (ph)
      PH_ST_SETUP, PH_RS_SETUP, PH_NACK_HIGH, PH_SP_END: p = '{1'b1, 1'b1, 1'b1};
      PH_ST_START, PH_RS_START, PH_SP_HIGH:              p = '{1'b1, 1'b0, 1'b1};
      PH_AW_LOW, PH_RG_LOW, PH_AR_LOW:                   p = '{1'b0, bit_lvl, 1'b1};
      PH_AW_HIGH, PH_RG_HIGH, PH_AR_HIGH:                p = '{1'b1, bit_lvl, 1'b1};
      PH_AW_ACK_LOW, PH_RG_ACK_LOW, PH_AR_ACK_LOW,
      PH_RD_LOW:                                         p = '{1'b0, 1'b1, 1'b0};
      PH_AW_ACK_HIGH, PH_RG_ACK_HIGH, PH_AR_ACK_HIGH,
      PH_RD_HIGH:                                        p = '{1'b1, 1'b1, 1'b0};
      PH_RS_LOW, PH_NACK_LOW:                            p = '{1'b0, 1'b1, 1'b1};
      PH_SP_LOW:                                         p = '{1'b0, 1'b0, 1'b1};
      default:                                           p = '{1'b1, 1'b1, 1'b1};
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/srbd_if.sv =====
// Request and result channel interfaces of the SMBus read-byte-data master.
interface srbd_req_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [srbd_pkg::AddrW-1:0] dev_addr;
  logic [srbd_pkg::ByteW-1:0] reg_index;
  logic                       sda_in;

  modport source (output valid, mode, dev_addr, reg_index, sda_in, input ready);
  modport sink (input valid, mode, dev_addr, reg_index, sda_in, output ready);
endinterface

interface srbd_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       scl;
  logic                       sda_out;
  logic                       sda_drive;
  logic                       busy_res;
  logic                       done_res;
  logic                       success;
  logic [srbd_pkg::ByteW-1:0] read_data;

  modport source (output valid, scl, sda_out, sda_drive, busy_res, done_res, success,
                  read_data, input ready);
  modport sink (input valid, scl, sda_out, sda_drive, busy_res, done_res, success,
                read_data, output ready);
endinterface

// ===== hdl/smbus_read_byte_data_master_top.sv =====
// Top level of the SMBus read-byte-data master sequencer.
//
// Bit-banged SMBus read-byte-data master. A request item with mode 1, taken
// while idle, latches the device address and register index and starts a
// transaction; every item taken while busy is one tick that advances the
// divider. After step_ticks ticks (0 acts as 1) a pin step ends and the
// sequencer moves on: start, address+write, ack, register byte, ack,
// repeated start, address+read, ack, eight data bits MSB first, master
// not-ack, stop. A high data line at any ack sample ends the transaction at
// once with success 0 and idle levels, no stop sent. Each request item
// yields exactly one result item holding the pin levels after that item,
// busy, a one-item done pulse, success and the byte read (zero unless done
// with success). Throughput is one item per clock: the state update is a
// single pass of logic from the state registers into a result register, and
// the request side stays ready whenever that register is empty or being
// drained in the same cycle. step_ticks is written through step_ticks_we_i/
// step_ticks_i and should only change while no transaction is running; it
// resets to 1.
`include "smbus_read_byte_data_master_top_assert.svh"

module smbus_read_byte_data_master_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_ticks_we_i,
  input  logic [srbd_pkg::StepW-1:0]   step_ticks_i,
  srbd_req_if.sink                     req_i,
  srbd_rsp_if.source                   rsp_o
);

  localparam int unsigned StepW   = srbd_pkg::StepW;
  localparam int unsigned AddrW   = srbd_pkg::AddrW;
  localparam int unsigned ByteW   = srbd_pkg::ByteW;
  localparam int unsigned BitCntW = srbd_pkg::BitCntW;

  // Sequencer state
  srbd_pkg::phase_e     phase_q, phase_d;
  logic [BitCntW-1:0]   bit_cnt_q, bit_cnt_d;
  logic [ByteW-1:0]     shift_q, shift_d;
  logic [AddrW-1:0]     addr_q, addr_d;
  logic [ByteW-1:0]     reg_q, reg_d;
  logic [StepW-1:0]     tick_q, tick_d;
  logic [StepW-1:0]     step_ticks_q;

  // Result register
  logic                 res_vld_q, res_vld_d;
  srbd_pkg::res_t       res_q, res_d;

  logic                 req_acc;
  logic [StepW-1:0]     limit;
  logic [StepW-1:0]     tick_inc;
  logic [BitCntW-1:0]   bit_inc;
  logic                 done;
  logic                 ok;

  assign req_i.ready = ~res_vld_q | rsp_o.ready;
  assign req_acc     = req_i.valid & req_i.ready;

  assign limit    = (step_ticks_q == '0) ? StepW'(1) : step_ticks_q;
  assign tick_inc = tick_q + StepW'(1);
  assign bit_inc  = bit_cnt_q + BitCntW'(1);

  // Next state for one item
  always_comb begin
    phase_d   = phase_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    addr_d    = addr_q;
    reg_d     = reg_q;
    tick_d    = tick_q;
    done      = 1'b0;
    ok        = 1'b0;
    if (req_acc) begin
      if (phase_q == srbd_pkg::PH_IDLE) begin
        if (req_i.mode) begin
          addr_d    = req_i.dev_addr;
          reg_d     = req_i.reg_index;
          bit_cnt_d = '0;
          shift_d   = '0;
          tick_d    = '0;
          phase_d   = srbd_pkg::PH_ST_SETUP;
        end
      end else begin
        tick_d = tick_inc;
        if (tick_inc >= limit) begin
          tick_d = '0;
          case (phase_q)
            srbd_pkg::PH_ST_START: begin
              shift_d   = {addr_q, 1'b0};
              bit_cnt_d = '0;
              phase_d   = srbd_pkg::PH_AW_LOW;
            end
            srbd_pkg::PH_RS_START: begin
              shift_d   = {addr_q, 1'b1};
              bit_cnt_d = '0;
              phase_d   = srbd_pkg::PH_AR_LOW;
            end
            // Shift out one bit; loop back to clock-low until the byte is sent
            srbd_pkg::PH_AW_HIGH, srbd_pkg::PH_RG_HIGH, srbd_pkg::PH_AR_HIGH: begin
              shift_d   = {shift_q[ByteW-2:0], 1'b0};
              bit_cnt_d = bit_inc;
              phase_d   = (bit_inc >= BitCntW'(ByteW))
                        ? srbd_pkg::phase_e'({phase_q[srbd_pkg::PhaseW-2:0], 1'b0})
                        : srbd_pkg::phase_e'({1'b0, phase_q[srbd_pkg::PhaseW-1:1]});
            end
            // Sample the acknowledge; a high line aborts the transaction
            srbd_pkg::PH_AW_ACK_HIGH, srbd_pkg::PH_RG_ACK_HIGH,
            srbd_pkg::PH_AR_ACK_HIGH: begin
              if (req_i.sda_in) begin
                done    = 1'b1;
                phase_d = srbd_pkg::PH_IDLE;
              end else if (phase_q == srbd_pkg::PH_AW_ACK_HIGH) begin
                shift_d   = reg_q;
                bit_cnt_d = '0;
                phase_d   = srbd_pkg::PH_RG_LOW;
              end else if (phase_q == srbd_pkg::PH_RG_ACK_HIGH) begin
                phase_d = srbd_pkg::PH_RS_LOW;
              end else begin
                shift_d   = '0;
                bit_cnt_d = '0;
                phase_d   = srbd_pkg::PH_RD_LOW;
              end
            end
            // Shift in one data bit, MSB first
            srbd_pkg::PH_RD_HIGH: begin
              shift_d   = {shift_q[ByteW-2:0], req_i.sda_in};
              bit_cnt_d = bit_inc;
              phase_d   = (bit_inc >= BitCntW'(ByteW)) ? srbd_pkg::PH_NACK_LOW
                                                       : srbd_pkg::PH_RD_LOW;
            end
            srbd_pkg::PH_SP_END: begin
              done    = 1'b1;
              ok      = 1'b1;
              phase_d = srbd_pkg::PH_IDLE;
            end
            // Plain steps advance to the next phase
            srbd_pkg::PH_ST_SETUP, srbd_pkg::PH_AW_LOW, srbd_pkg::PH_AW_ACK_LOW,
            srbd_pkg::PH_RG_LOW, srbd_pkg::PH_RG_ACK_LOW, srbd_pkg::PH_RS_LOW,
            srbd_pkg::PH_RS_SETUP, srbd_pkg::PH_AR_LOW, srbd_pkg::PH_AR_ACK_LOW,
            srbd_pkg::PH_RD_LOW, srbd_pkg::PH_NACK_LOW, srbd_pkg::PH_NACK_HIGH,
            srbd_pkg::PH_SP_LOW, srbd_pkg::PH_SP_HIGH: begin
              phase_d = srbd_pkg::phase_e'({phase_q[srbd_pkg::PhaseW-2:0], 1'b0});
            end
            default: begin
              phase_d = srbd_pkg::PH_IDLE;
            end
          endcase
        end
      end
    end
  end

  // Result for the item just taken
  always_comb begin
    res_d.pins      = srbd_pkg::levels_for(phase_d, shift_d[ByteW-1]);
    res_d.busy      = (phase_d != srbd_pkg::PH_IDLE);
    res_d.done      = done;
    res_d.success   = done & ok;
    res_d.read_data = (done & ok) ? shift_d : '0;
  end

  // Hold the result until taken; refill in the same cycle it drains
  assign res_vld_d = req_acc | (res_vld_q & ~rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= srbd_pkg::PH_IDLE;
      bit_cnt_q    <= '0;
      shift_q      <= '0;
      addr_q       <= '0;
      reg_q        <= '0;
      tick_q       <= '0;
      step_ticks_q <= StepW'(1);
      res_vld_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      shift_q   <= shift_d;
      addr_q    <= addr_d;
      reg_q     <= reg_d;
      tick_q    <= tick_d;
      res_vld_q <= res_vld_d;
      if (step_ticks_we_i) begin
        step_ticks_q <= step_ticks_i;
      end
    end
  end

  // Payload needs no reset; load on accept only
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      res_q <= res_d;
    end
  end

  assign rsp_o.valid     = res_vld_q;
  assign rsp_o.scl       = res_q.pins.scl;
  assign rsp_o.sda_out   = res_q.pins.sda;
  assign rsp_o.sda_drive = res_q.pins.drv;
  assign rsp_o.busy_res  = res_q.busy;
  assign rsp_o.done_res  = res_q.done;
  assign rsp_o.success   = res_q.success;
  assign rsp_o.read_data = res_q.read_data;

  // A begin taken while idle must enter the start set-up step
  `SRBD_ASSERT_NEXT(a_begin_enters_setup,
    req_acc && req_i.mode && phase_q == srbd_pkg::PH_IDLE,
    phase_q == srbd_pkg::PH_ST_SETUP, "begin item did not start the sequence")
  // A finished transaction is never reported as still busy
  `SRBD_ASSERT_SAME(a_done_not_busy, res_vld_q && res_q.done,
    !res_q.busy, "done reported while busy")
  // Read data is zero unless the transaction completed with success
  `SRBD_ASSERT_SAME(a_data_only_on_success, res_vld_q && !res_q.success,
    res_q.read_data == '0, "read data without a successful end")
  // The bit counter never runs past one byte
  `SRBD_ASSERT_SAME(a_bit_cnt_range, 1'b1,
    bit_cnt_q <= BitCntW'(ByteW), "bit counter overran a byte")

endmodule
